// ===== hdl/mbss_pkg.sv =====
// Shared types, constants and register codes for the masked byte signature scan.
package mbss_pkg;

   localparam int BYTE_BITS        = 8;
   localparam int PATTERN_SLOTS    = 16;
   localparam int SLOT_INDEX_BITS  = 4;
   localparam int LEN_BITS         = 5;
   localparam int CARE_BITS        = 16;
   localparam int ADDR_BITS        = 48;
   localparam int CSR_DATA_BITS    = 64;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int PATTERN_WORD_BITS = 64;

   localparam int MAX_PATTERN_BYTES_DEFAULT = 16;
   localparam int OFFSET_BITS_DEFAULT       = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_REGION_BASE  = 3'd4
   } csr_index_type;

   typedef logic [PATTERN_SLOTS-1:0][BYTE_BITS-1:0] pattern_type;

   // Window entry handed from one cell to the next
   typedef struct packed {
      logic                 filled;
      logic [BYTE_BITS-1:0] value;
   } cell_data_type;

   // Control shared by every cell of the chain
   typedef struct packed {
      logic                shift;
      logic                clear;
      logic [LEN_BITS-1:0] len;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] address;
   } result_type;

endpackage

// ===== hdl/masked_byte_signature_scan.sv =====
// Masked byte signature scan: one byte per cycle through a chain of window cells while the result buffer has room.
// A result is pushed into the result buffer when the byte that causes it is accepted; rsp is driven from that buffer.
// Throughput: one byte per cycle while req_tready is high; every cell compares its byte in parallel each cycle.
// A two-entry result buffer lets bytes keep flowing while a result waits.
// Reset (synchronous): clears registers to defaults, window, offset and match flag.
module masked_byte_signature_scan #(
   parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES_DEFAULT,
   parameter int OFFSET_BITS       = mbss_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] data_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mbss_pkg::ADDR_BITS-1:0]       rsp_tdata,   // [47:0] match_address
   output logic [0:0]                           rsp_tuser,   // [0] found
   input  logic                                 csr_wr_en,
   input  logic [mbss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mbss_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import mbss_pkg::*;

   logic [PATTERN_WORD_BITS-1:0] pattern_low_ff;
   logic [PATTERN_WORD_BITS-1:0] pattern_high_ff;
   logic [CARE_BITS-1:0]         care_mask_ff;
   logic [LEN_BITS-1:0]          pattern_len_ff;
   logic [ADDR_BITS-1:0]         region_base_ff;

   logic [OFFSET_BITS-1:0]       offset_ff;
   logic [OFFSET_BITS-1:0]       offset_in;
   logic                         reported_ff;
   logic                         reported_in;

   logic [LEN_BITS-1:0]          len_eff;
   pattern_type                  pattern;
   cell_ctrl_type                ctrl;
   cell_data_type                chain [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] hit_vec;
   logic [MAX_PATTERN_BYTES-1:0] tail_vec;

   logic        accept;
   logic        active;
   logic        match;
   logic        push;
   logic        buf_full;
   result_type  push_data;
   result_type  out_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= '0;
         pattern_len_ff  <= LEN_BITS'(1);
         region_base_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_wr_data;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_wr_data;
            CSR_CARE_MASK:    care_mask_ff    <= csr_wr_data[CARE_BITS-1:0];
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_wr_data[LEN_BITS-1:0];
            CSR_REGION_BASE:  region_base_ff  <= csr_wr_data[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pattern_len_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (pattern_len_ff > LEN_BITS'(MAX_PATTERN_BYTES)) begin
         len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = pattern_len_ff;
      end
   end

   assign pattern = {pattern_high_ff, pattern_low_ff};

   assign accept = req_tvalid && req_tready;
   // Drop bytes after a match or once the offset saturates
   assign active = !reported_ff && (offset_ff != '1);

   assign ctrl.shift = accept && active;
   assign ctrl.clear = accept && req_tlast;
   assign ctrl.len   = len_eff;

   assign chain[0].filled = 1'b1;
   assign chain[0].value  = req_tdata;

   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      if (k == MAX_PATTERN_BYTES - 1) begin : g_end
         mbss_cell #(
            .CELL_INDEX(k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .pattern   (pattern),
            .care      (care_mask_ff),
            .prev_data (chain[k]),
            .data_out  (),
            .hit       (hit_vec[k]),
            .tail      (tail_vec[k])
         );
      end else begin : g_mid
         mbss_cell #(
            .CELL_INDEX(k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .pattern   (pattern),
            .care      (care_mask_ff),
            .prev_data (chain[k]),
            .data_out  (chain[k+1]),
            .hit       (hit_vec[k]),
            .tail      (tail_vec[k])
         );
      end
   end

   // The tail cell is filled only once the window holds at least len bytes
   assign match = ctrl.shift && (|tail_vec) && (&hit_vec);

   always_comb begin
      offset_in   = offset_ff;
      reported_in = reported_ff;
      if (ctrl.shift) begin
         offset_in = offset_ff + OFFSET_BITS'(1);
      end
      if (match) begin
         reported_in = 1'b1;
      end
      if (ctrl.clear) begin
         offset_in   = '0;
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         reported_ff <= 1'b0;
      end else begin
         offset_ff   <= offset_in;
         reported_ff <= reported_in;
      end
   end

   // Window start = region base + offset after this byte minus length
   always_comb begin
      push = match || (accept && req_tlast && !reported_ff);
      push_data.found = match;
      if (match) begin
         push_data.address = region_base_ff + ADDR_BITS'(offset_ff) + ADDR_BITS'(1)
                             - ADDR_BITS'(len_eff);
      end else begin
         push_data.address = '0;
      end
   end

   mbss_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .full      (buf_full)
   );

   assign req_tready   = !buf_full;
   assign rsp_tdata    = out_data.address;
   assign rsp_tuser[0] = out_data.found;

endmodule

// ===== hdl/mbss_cell.sv =====
// One window cell: holds a byte, shifts it on, and checks its incoming byte against the pattern.
module mbss_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mbss_pkg::cell_ctrl_type ctrl,
   input  mbss_pkg::pattern_type  pattern,
   input  logic [mbss_pkg::CARE_BITS-1:0] care,
   input  mbss_pkg::cell_data_type prev_data,
   output mbss_pkg::cell_data_type data_out,
   output logic                   hit,
   output logic                   tail
);
   import mbss_pkg::*;

   logic                       filled_ff;
   logic                       filled_in;
   logic [BYTE_BITS-1:0]       value_ff;
   logic [BYTE_BITS-1:0]       value_in;
   logic [LEN_BITS-1:0]        slot;
   logic [SLOT_INDEX_BITS-1:0] slot_sel;
   logic                       in_use;

   // The oldest byte of the window meets pattern byte 0
   always_comb begin
      slot     = ctrl.len - LEN_BITS'(1) - LEN_BITS'(CELL_INDEX);
      slot_sel = slot[SLOT_INDEX_BITS-1:0];
      in_use   = (LEN_BITS'(CELL_INDEX) < ctrl.len) && care[slot_sel];
      hit      = !in_use || (prev_data.value == pattern[slot_sel]);
      tail     = (LEN_BITS'(CELL_INDEX) == ctrl.len - LEN_BITS'(1)) && prev_data.filled;
   end

   always_comb begin
      filled_in = filled_ff;
      value_in  = value_ff;
      if (ctrl.shift) begin
         filled_in = prev_data.filled;
         value_in  = prev_data.value;
      end
      if (ctrl.clear) begin
         filled_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign data_out.filled = filled_ff;
   assign data_out.value  = value_ff;

endmodule

// ===== hdl/mbss_out_fifo.sv =====
// Two-entry result buffer between the scan chain and the result channel.
module mbss_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mbss_pkg::result_type push_data,
   input  logic                pop_ready,
   output logic                out_valid,
   output mbss_pkg::result_type out_data,
   output logic                full
);
   import mbss_pkg::*;

   result_type  slot_ff [2];
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        pop;
   logic        wr_ptr;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;
   assign wr_ptr    = rd_ptr_ff ^ count_ff[0];

   always_comb begin
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr] <= push_data;
      end
   end

endmodule

// ===== dv/tb.sv =====
// Testbench for masked_byte_signature_scan: streams byte regions and checks each match result.
`timescale 1ns / 100ps

module tb;
   import mbss_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_SETTLE  = 4;
   localparam int MAX_PRINTS   = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } scan_item_type;

   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_BUSY} rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [ADDR_BITS-1:0]      rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   masked_byte_signature_scan u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // scanner shadow: configuration
   logic [PATTERN_WORD_BITS-1:0] pat_low_cfg;
   logic [PATTERN_WORD_BITS-1:0] pat_high_cfg;
   logic [CARE_BITS-1:0]         care_cfg;
   logic [LEN_BITS-1:0]          len_cfg;
   logic [ADDR_BITS-1:0]         base_cfg;
   // scanner shadow: region state
   logic [BYTE_BITS-1:0]         window_bytes [PATTERN_SLOTS];
   logic [31:0]                  scan_offset;
   bit                           match_seen;

   scan_item_type pending_bytes_q [$];
   result_type    scan_results_q  [$];

   int          error_count = 0;
   int          cycle_count = 0;
   int          items_queued = 0;
   bit          req_fire = 1'b0;
   int          gap_left = 0;
   int          burst_left = 1;
   bit          drain_hold = 1'b0;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("masked_byte_signature_scan test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic logic [7:0] pattern_byte(input int j);
      if (j < 8)
         return pat_low_cfg[j*8 +: 8];
      return pat_high_cfg[(j-8)*8 +: 8];
   endfunction

   function automatic int effective_length();
      if (len_cfg == 0)
         return 1;
      if (len_cfg > PATTERN_SLOTS)
         return PATTERN_SLOTS;
      return int'(len_cfg);
   endfunction

   function automatic void clear_window();
      foreach (window_bytes[i])
         window_bytes[i] = '0;
      scan_offset = '0;
      match_seen  = 1'b0;
   endfunction

   // Advance the shadow scanner by one byte; return 1 when it yields a result.
   function automatic bit scan_byte(input logic [7:0] data, input logic last,
                                    output result_type res);
      int len;
      bit emit;
      bit hit;
      emit = 1'b0;
      res  = '0;
      if (!match_seen && scan_offset != '1) begin
         len = effective_length();
         for (int i = PATTERN_SLOTS - 1; i > 0; i--)
            window_bytes[i] = window_bytes[i-1];
         window_bytes[0] = data;
         scan_offset++;
         if (scan_offset >= len) begin
            hit = 1'b1;
            for (int j = 0; j < len; j++)
               if (care_cfg[j] && window_bytes[len-1-j] != pattern_byte(j))
                  hit = 1'b0;
            if (hit) begin
               res.found   = 1'b1;
               res.address = base_cfg + (48'(scan_offset) - 48'(len));
               match_seen  = 1'b1;
               emit        = 1'b1;
            end
         end
      end
      if (last) begin
         if (!match_seen) begin
            res  = '0;
            emit = 1'b1;
         end
         clear_window();
      end
      return emit;
   endfunction

   // Monitor: predict on accepted items, apply register writes, check results.
   always @(posedge clock) begin
      result_type res;
      result_type want;
      req_fire <= req_tvalid && req_tready && !reset;
      if (reset) begin
         pat_low_cfg  = '0;
         pat_high_cfg = '0;
         care_cfg     = '0;
         len_cfg      = LEN_BITS'(1);
         base_cfg     = '0;
         clear_window();
      end else begin
         if (req_tvalid && req_tready) begin
            if (scan_byte(req_tdata, req_tlast, res))
               scan_results_q.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (scan_results_q.size() == 0) begin
               report_mismatch($sformatf("result with none expected: found %0b addr %h",
                                         rsp_tuser[0], rsp_tdata));
            end else begin
               want = scan_results_q.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report_mismatch($sformatf("found %b, expected %b", rsp_tuser[0], want.found));
               if (rsp_tdata !== want.address)
                  report_mismatch($sformatf("match_address %h, expected %h",
                                            rsp_tdata, want.address));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_LOW:  pat_low_cfg  = csr_wr_data;
               CSR_PATTERN_HIGH: pat_high_cfg = csr_wr_data;
               CSR_CARE_MASK:    care_cfg     = csr_wr_data[CARE_BITS-1:0];
               CSR_PATTERN_LEN:  len_cfg      = csr_wr_data[LEN_BITS-1:0];
               CSR_REGION_BASE:  base_cfg     = csr_wr_data[ADDR_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Driver: bursts of items with random gaps, occasional hold until results drain.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            void'(pending_bytes_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               if ($urandom_range(0, 15) == 0)
                  drain_hold = 1'b1;
            end
         end
         if (req_tvalid && !req_fire) begin
            // hold the item until the block takes it
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (drain_hold && scan_results_q.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            drain_hold = 1'b0;
            if (pending_bytes_q.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes_q[0].data;
               req_tlast  <= pending_bytes_q[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern switching between open, choppy and mostly busy.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(5, 60);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic push_item(input logic [7:0] data, input logic last);
      scan_item_type it;
      it.data = data;
      it.last = last;
      pending_bytes_q.push_back(it);
      items_queued++;
   endtask

   // Wait until the block has taken everything and every result is back.
   task automatic wait_idle();
      while (pending_bytes_q.size() != 0 || req_tvalid || scan_results_q.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Queue one region; optionally plant the configured pattern inside it.
   task automatic add_region(input int n, input bit plant);
      logic [7:0] bytes [$];
      int len;
      int pos;
      len = effective_length();
      for (int i = 0; i < n; i++)
         bytes.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                      : pattern_byte($urandom_range(0, 15)));
      if (plant && n >= len) begin
         pos = $urandom_range(0, n - len);
         for (int j = 0; j < len; j++)
            if (care_cfg[j] || $urandom_range(0, 3) == 0)
               bytes[pos+j] = pattern_byte(j);
      end
      for (int i = 0; i < n; i++)
         push_item(bytes[i], i == n - 1);
   endtask

   task automatic random_config();
      logic [CSR_DATA_BITS-1:0] value;
      if ($urandom_range(0, 3) != 0)
         csr_write(CSR_PATTERN_LOW, {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0)
         csr_write(CSR_PATTERN_HIGH, {$urandom, $urandom});
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       value[CARE_BITS-1:0] = '0;
         1, 2:    value[CARE_BITS-1:0] = '1;
         default: ;
      endcase
      if ($urandom_range(0, 3) != 0)
         csr_write(CSR_CARE_MASK, value);
      value = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0:       value[LEN_BITS-1:0] = '0;
         1, 2:    value[LEN_BITS-1:0] = LEN_BITS'($urandom_range(17, 31));
         3:       value[LEN_BITS-1:0] = LEN_BITS'(PATTERN_SLOTS);
         default: value[LEN_BITS-1:0] = LEN_BITS'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 3) != 0)
         csr_write(CSR_PATTERN_LEN, value);
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       value[ADDR_BITS-1:0] = '0;
         1:       value[ADDR_BITS-1:0] = '1 - 48'($urandom_range(0, 20));
         default: ;
      endcase
      if ($urandom_range(0, 3) != 0)
         csr_write(CSR_REGION_BASE, value);
   endtask

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one-byte pattern, nothing cared for, so every byte matches
      @(posedge clock);
      push_item(8'h00, 1'b1);
      push_item(8'hFF, 1'b0);
      push_item(8'h5A, 1'b0);
      push_item(8'h00, 1'b1);
      wait_idle();

      // length zero acts as one; base at the top so the address wraps
      csr_write(CSR_PATTERN_LOW, '1);
      csr_write(CSR_CARE_MASK, {{(CSR_DATA_BITS-1){1'b1}}, 1'b1} & 64'h1);
      csr_write(CSR_PATTERN_LEN, '0);
      csr_write(CSR_REGION_BASE, '1);
      // unused indexes must not disturb anything
      for (int k = int'(CSR_REGION_BASE) + 1; k < 2**CSR_INDEX_BITS; k++)
         csr_write(CSR_INDEX_BITS'(k), '0);
      @(posedge clock);
      push_item(8'h00, 1'b0);
      push_item(8'h7F, 1'b0);
      push_item(8'hFF, 1'b1);
      push_item(8'h00, 1'b0);
      push_item(8'h01, 1'b1);
      wait_idle();

      // oversized length clamps to the full window; short region, then match on last byte
      csr_write(CSR_PATTERN_LOW, 64'h0706_0504_0302_0100);
      csr_write(CSR_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
      csr_write(CSR_CARE_MASK, '1);
      csr_write(CSR_PATTERN_LEN, '1);
      csr_write(CSR_REGION_BASE, 64'hFFFF_0000_0000_1000);
      @(posedge clock);
      for (int i = 0; i < 3; i++)
         push_item(8'(i), i == 2);
      for (int i = 0; i < PATTERN_SLOTS; i++)
         push_item(8'(i), i == PATTERN_SLOTS - 1);
      wait_idle();

      items_queued = 0;
      while (items_queued < RANDOM_ITEMS) begin
         random_config();
         @(posedge clock);
         repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 19))
               0:       add_region(1, 1'b1);
               1, 2, 3: add_region($urandom_range(21, 40), $urandom_range(0, 3) != 0);
               default: add_region($urandom_range(1, 20), $urandom_range(0, 3) != 0);
            endcase
         end
         wait_idle();
      end

      waited = 0;
      while ((pending_bytes_q.size() != 0 || scan_results_q.size() != 0) && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (scan_results_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   scan_results_q.size()));
      if (error_count == 0)
         $display("masked_byte_signature_scan test passed");
      else
         $display("masked_byte_signature_scan test failed");
      $finish;
   end

endmodule
